FILE: src/tam_pkg.sv
// ----------------------------------------------------------------------------
// tam_pkg : shared types, constants and the sine table generator
// Word layouts of both channels, register codes and the quarter-wave table
// entry function evaluated at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

package tam_pkg;

  localparam int SAMPLE_BITS         = 24;
  localparam int PHASE_BITS_DEF      = 32;
  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int CHANNELS_DEF        = 3;
  localparam int NUM_FIELDS          = 3;

  localparam int STEP_BITS     = 32;
  localparam int DEPTH_BITS    = 16;
  localparam int AT_BITS       = 16;
  localparam int SINE_MAG_BITS = 15;
  localparam int GAIN_BITS     = 33;
  localparam int PROD_BITS     = SAMPLE_BITS + GAIN_BITS;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [CFG_IDX_BITS-1:0] CFG_PHASE_STEP    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEPTH         = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_USE_AFTERTOUCH = 2'd2;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned TAYLOR_DEN [6] = '{64'd6, 64'd20, 64'd42,
                                                 64'd72, 64'd110, 64'd156};
  localparam longint unsigned SINE_MAX = 64'd32767;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_main;
    logic signed [SAMPLE_BITS-1:0] sample_aux_a;
    logic signed [SAMPLE_BITS-1:0] sample_aux_b;
    logic [1:0]                    channel_count;
    logic [AT_BITS-1:0]            aftertouch;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_main;
    logic signed [SAMPLE_BITS-1:0] out_aux_a;
    logic signed [SAMPLE_BITS-1:0] out_aux_b;
    logic                          saturated;
  } out_word_t;

  typedef struct packed {
    sample_t sample;
    logic    sat;
    logic    present;
  } lane_res_t;

  // sin(pi/2 * k / 2^tbits) in Q0.15 via Q30 Taylor series
  function automatic logic [SINE_MAG_BITS-1:0] sine_entry(input int unsigned k,
                                                         input int unsigned tbits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned q;
    longint          sum;
    x    = (longint'(k) * HALF_PI_Q30) >> tbits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 6; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DEN[n-1];
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    q = (longint'(sum) * SINE_MAX + (64'd1 << 29)) >> 30;
    if (q > SINE_MAX) begin
      q = SINE_MAX;
    end
    return q[SINE_MAG_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: src/tam_stream_if.sv
// ----------------------------------------------------------------------------
// tam_stream_if : valid/ready channel
// One word moves at each clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface tam_stream_if #(
  parameter type word_t = logic
) ();
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/tam_ram.sv
// ----------------------------------------------------------------------------
// tam_ram : generic simple dual-port RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module tam_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: src/tam_lane.sv
// ----------------------------------------------------------------------------
// tam_lane : one channel of the modulator
// Multiply the sample by the Q30 gain, then round half up and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module tam_lane (
  input  wire logic                                   clk,
  input  wire logic                                   en,
  input  wire tam_pkg::sample_t                       sample,
  input  wire logic signed [tam_pkg::GAIN_BITS-1:0]   gain,
  input  wire logic                                   present,
  output tam_pkg::lane_res_t                          res
);

  localparam int PB = tam_pkg::PROD_BITS;
  localparam int SB = tam_pkg::SAMPLE_BITS;
  localparam int YW = PB - 30;

  logic signed [PB-1:0] prod_r;
  logic                 pres_a_r;
  logic signed [PB-1:0] rnd;
  logic        [YW-1:0] y_full;
  logic                 ovf;
  tam_pkg::sample_t     y_sat;
  tam_pkg::lane_res_t   res_r;
  tam_pkg::lane_res_t   res_nxt;

  assign rnd    = prod_r + PB'(64'd1 << 29);
  assign y_full = rnd[PB-1:30];
  assign ovf    = !((&y_full[YW-1:SB-1]) || !(|y_full[YW-1:SB-1]));

  always_comb begin
    if (!ovf) begin
      y_sat = $signed(y_full[SB-1:0]);
    end else if (y_full[YW-1]) begin
      y_sat = $signed({1'b1, {(SB-1){1'b0}}});
    end else begin
      y_sat = $signed({1'b0, {(SB-1){1'b1}}});
    end
    res_nxt.sample  = pres_a_r ? y_sat : '0;
    res_nxt.sat     = pres_a_r && ovf;
    res_nxt.present = pres_a_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r   <= PB'(sample) * PB'(gain);
      pres_a_r <= present;
      res_r    <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

FILE: src/tremolo_amplitude_modulator.sv
// ----------------------------------------------------------------------------
// tremolo_amplitude_modulator : LFO tremolo on up to three audio channels
// Each present sample is scaled by 1 + at*depth*sin(phase), rounded and
// saturated; a shared phase accumulator advances once per non-empty frame.
// ----------------------------------------------------------------------------
//
//   channel | direction | word         | handshake
//   --------+-----------+--------------+------------------------------
//   in_ch   | input     | in_word_t    | valid/ready, taken on both high
//   out_ch  | output    | out_word_t   | valid/ready, taken on both high
//   cfg_*   | input     | index + data | write on cfg_we, no read-back
//
// One frame per cycle sustained while the output is not stalled; a taken frame
// passes through the registered stages table read, gain multiply, sample multiply and round/saturate.
// After reset the sine RAM is loaded one entry a cycle, 2^SINE_TABLE_BITS+1
// entries (1025 by default); in_ch.ready stays low until the load is done.
// A stalled output freezes the whole pipeline, RAM read register included.
//
`default_nettype none

module tremolo_amplitude_modulator #(
  parameter int PHASE_BITS      = tam_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_BITS = tam_pkg::SINE_TABLE_BITS_DEF,
  parameter int CHANNELS        = tam_pkg::CHANNELS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  tam_stream_if.sink                              in_ch,
  tam_stream_if.source                            out_ch,
  input  wire logic                               cfg_we,
  input  wire logic [tam_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [tam_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

  localparam int NF          = tam_pkg::NUM_FIELDS;
  localparam int TB          = SINE_TABLE_BITS;
  localparam int TAB_ENTRIES = (1 << TB) + 1;
  localparam int AW          = $clog2(TAB_ENTRIES);
  localparam int LANES       = (CHANNELS < NF) ? CHANNELS : NF;
  localparam int MW          = tam_pkg::SINE_MAG_BITS;
  localparam int GW          = tam_pkg::GAIN_BITS;

  localparam logic [AW-1:0]        TAB_LAST = AW'(1 << TB);
  localparam logic signed [GW-1:0] GAIN_ONE = GW'(64'd1 << 30);
  localparam logic [16:0]          AT_FULL  = 17'h1_0000;

  // configuration registers
  logic [tam_pkg::STEP_BITS-1:0]  phase_step_r;
  logic [tam_pkg::DEPTH_BITS-1:0] depth_r;
  logic                           use_at_r;

  // table load sweep
  logic          fill_busy_r;
  logic [AW-1:0] fill_cnt_r;
  logic [MW-1:0] sine_rom [TAB_ENTRIES];

  // handshake and phase
  logic                  advance;
  logic                  accept;
  logic [PHASE_BITS-1:0] phase_r;
  logic [TB+1:0]         top_bits;
  logic [AW-1:0]         rd_addr;
  logic [MW-1:0]         sine_mag;

  // stage 1: table read in flight
  logic                   v1_r;
  tam_pkg::sample_t       samp1_r [NF];
  logic [NF-1:0]          pres1_r;
  logic                   neg1_r;
  logic [15:0]            m1_r;
  tam_pkg::sample_t       samp_in [NF];
  logic [NF-1:0]          pres_nxt;
  logic [16:0]            at_eff;
  logic [32:0]            at_prod;

  // stage 2: gain ready
  logic                   v2_r;
  tam_pkg::sample_t       samp2_r [NF];
  logic [NF-1:0]          pres2_r;
  logic signed [GW-1:0]   gain2_r;
  logic signed [MW:0]     sine_s;
  logic signed [GW-1:0]   mprod;

  // lanes and merge
  logic                   v3_r;
  logic                   out_valid_r;
  tam_pkg::lane_res_t     lane_res [NF];
  logic [NF-1:0]          lane_sat;
  logic [NF-1:0]          lane_pres;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= '0;
      depth_r      <= '0;
      use_at_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        tam_pkg::CFG_PHASE_STEP:     phase_step_r <= cfg_wdata;
        tam_pkg::CFG_DEPTH:          depth_r      <= cfg_wdata[tam_pkg::DEPTH_BITS-1:0];
        tam_pkg::CFG_USE_AFTERTOUCH: use_at_r     <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Quarter-wave table constants, folded at elaboration.
  for (genvar k = 0; k < TAB_ENTRIES; k++) begin : g_rom
    assign sine_rom[k] = tam_pkg::sine_entry(k, TB);
  end

  // Load the sine RAM after reset, one entry per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_busy_r <= 1'b1;
      fill_cnt_r  <= '0;
    end else if (fill_busy_r) begin
      fill_cnt_r <= fill_cnt_r + AW'(1);
      if (fill_cnt_r == TAB_LAST) begin
        fill_busy_r <= 1'b0;
      end
    end
  end

  // Whole pipeline moves together; stall only when the output word waits.
  assign advance      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !fill_busy_r && advance;
  assign accept       = in_ch.valid && in_ch.ready;

  // Split the phase into quadrant and table index; mirror odd quadrants.
  assign top_bits = phase_r[PHASE_BITS-1 -: TB+2];
  assign rd_addr  = top_bits[TB] ? (TAB_LAST - AW'(top_bits[TB-1:0]))
                                 : AW'(top_bits[TB-1:0]);

  tam_ram #(
    .WIDTH (MW),
    .DEPTH (TAB_ENTRIES)
  ) u_sine_ram (
    .clk   (clk),
    .we    (fill_busy_r),
    .waddr (fill_cnt_r),
    .wdata (sine_rom[fill_cnt_r]),
    .re    (advance),
    .raddr (rd_addr),
    .rdata (sine_mag)
  );

  // Advance the phase on every frame that carries channels.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (accept && (in_ch.data.channel_count != 2'd0)) begin
      phase_r <= phase_r + PHASE_BITS'(phase_step_r);
    end
  end

  // Modulation index m = at * depth >> 16, with full-scale aftertouch when off.
  assign at_eff  = use_at_r ? {1'b0, in_ch.data.aftertouch} : AT_FULL;
  assign at_prod = 33'(at_eff) * 33'(depth_r);

  assign samp_in[0] = in_ch.data.sample_main;
  assign samp_in[1] = in_ch.data.sample_aux_a;
  assign samp_in[2] = in_ch.data.sample_aux_b;

  always_comb begin
    for (int i = 0; i < NF; i++) begin
      pres_nxt[i] = (in_ch.data.channel_count > 2'(i)) && (i < LANES);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      samp1_r <= samp_in;
      pres1_r <= pres_nxt;
      neg1_r  <= top_bits[TB+1];
      m1_r    <= at_prod[31:16];
    end
  end

  // Gain = 1.0 + m * sin in Q30.
  assign sine_s = neg1_r ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});
  assign mprod  = $signed({1'b0, m1_r}) * sine_s;

  always_ff @(posedge clk) begin
    if (advance) begin
      samp2_r <= samp1_r;
      pres2_r <= pres1_r;
      gain2_r <= mprod + GAIN_ONE;
    end
  end

  // Lanes: one per channel that the build supports; the rest read as zero.
  for (genvar i = 0; i < NF; i++) begin : g_lane
    if (i < LANES) begin : g_on
      tam_lane u_lane (
        .clk     (clk),
        .en      (advance),
        .sample  (samp2_r[i]),
        .gain    (gain2_r),
        .present (pres2_r[i]),
        .res     (lane_res[i])
      );
    end else begin : g_off
      assign lane_res[i] = '0;
    end
    assign lane_sat[i]  = lane_res[i].sat;
    assign lane_pres[i] = lane_res[i].present;
  end

  // Valid bits follow the data through the stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      v1_r        <= accept;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  // Merge: collect lane samples and OR the clip flags.
  assign out_ch.valid          = out_valid_r;
  assign out_ch.data.out_main  = lane_res[0].sample;
  assign out_ch.data.out_aux_a = lane_res[1].sample;
  assign out_ch.data.out_aux_b = lane_res[2].sample;
  assign out_ch.data.saturated = |lane_sat;

`ifndef SYNTHESIS
  // A frame with no channels leaves the phase untouched.
  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.data.channel_count == 2'd0) |=> $stable(phase_r))
    else $error("phase moved on an empty frame");

  // The table load runs once after reset and never restarts.
  a_fill_once: assert property (@(posedge clk) disable iff (!rst_n)
    !fill_busy_r |=> !fill_busy_r)
    else $error("sine table load restarted");

  // An output word without present channels is all zero.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && lane_pres == '0) |-> (out_ch.data == '0))
    else $error("empty frame produced nonzero output");

  // No frame enters while the table is loading.
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    fill_busy_r |=> !v1_r)
    else $error("frame accepted during table load");
`endif

endmodule

`default_nettype wire
